[rtl/gpf_pkg.sv]
// shared types and constants for the gravity pair force unit
`default_nettype none
package gpf_pkg;

    // field widths fixed by the interface
    localparam int MASS_W     = 32;
    localparam int GRAV_W     = 32;
    localparam int SOFT_W     = 16;
    localparam int FORCE_W    = 48;
    localparam int K_W        = GRAV_W + 2 * MASS_W;
    localparam int MUL_CHUNK  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT = 1'b1;

    localparam logic [GRAV_W-1:0] GRAV_RESET = 32'd65536;
    localparam logic [SOFT_W-1:0] SOFT_RESET = 16'd1;

    // force clip limits as magnitudes
    localparam logic [FORCE_W-1:0] FORCE_POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_NEG_MAG = {1'b1, {(FORCE_W-1){1'b0}}};

    // direction of one separation component
    typedef struct packed {
        logic nz;
        logic pos;
    } t_dir;

endpackage
`default_nettype wire

[rtl/gravity_pair_force_unit.sv]
// top level of the softened pair force unit
//
// Takes one body pair per clock and returns the softened Newtonian force on
// the second body, F = r * (-G*ma*mb / (|r| + softening)^3), as three signed
// Q32.16 components that clip to range and raise o_saturated. Throughput is
// one pair per cycle while the back end is not stalled. The path from push
// to the output queue runs through a chain of units:
// 32x32 partial product multipliers (one product per stage), a square root
// that resolves one bit per stage (COORD_WIDTH + 2 stages) and dividers with
// one overflow stage plus 48 quotient stages. The whole back end stalls as
// one when the output queue is full and a finished result waits to enter it,
// and the input queue then fills. Configuration is taken at any time but may
// only change while no pair is in flight.
`default_nettype none
module gravity_pair_force_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [gpf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [gpf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pair input
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [gpf_pkg::MASS_W-1:0]          i_mass_a,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_a_x,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_a_y,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_a_z,
    input  wire logic [gpf_pkg::MASS_W-1:0]          i_mass_b,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_b_x,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_b_y,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_b_z,
    // force output
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [gpf_pkg::FORCE_W-1:0]       o_force_x,
    output logic signed [gpf_pkg::FORCE_W-1:0]       o_force_y,
    output logic signed [gpf_pkg::FORCE_W-1:0]       o_force_z,
    output logic                                     o_saturated
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int MAGW  = 3 * DW;
    localparam int DIRW  = 6;
    localparam int MW    = gpf_pkg::MASS_W;
    localparam int KW    = gpf_pkg::K_W;
    localparam int RW    = DW + 1;
    localparam int DSTW  = RW + 1;
    localparam int D3W   = 3 * DSTW;
    localparam int NW    = KW + DW;
    localparam int FW    = gpf_pkg::FORCE_W;
    localparam int MIDW  = 2 * MW + DIRW + MAGW;
    localparam int OUTW  = 3 * FW + 1;
    localparam int QDEPTH = 4;
    localparam int SW1   = MW + DIRW + MAGW;
    localparam int SW2   = DIRW + MAGW;
    localparam int SW3   = KW + DIRW + MAGW;
    localparam int SW4   = DSTW + SW3;
    localparam int SW6   = D3W + DIRW;

    // configuration registers
    logic [gpf_pkg::GRAV_W-1:0] r_grav;
    logic [gpf_pkg::SOFT_W-1:0] r_soft;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= gpf_pkg::GRAV_RESET;
            r_soft <= gpf_pkg::SOFT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gpf_pkg::REG_GRAV: r_grav <= i_cfg_data[gpf_pkg::GRAV_W-1:0];
                gpf_pkg::REG_SOFT: r_soft <= i_cfg_data[gpf_pkg::SOFT_W-1:0];
            endcase
        end
    end

    // front end
    logic                fr_vld;
    logic                mid_full;
    logic [MAGW-1:0]     fr_mag;
    gpf_pkg::t_dir [2:0] fr_dir;
    logic [MW-1:0]       fr_ma;
    logic [MW-1:0]       fr_mb;

    gpf_front #(.CW(CW)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_mass_a  (i_mass_a),
        .i_pos_a_x (i_pos_a_x),
        .i_pos_a_y (i_pos_a_y),
        .i_pos_a_z (i_pos_a_z),
        .i_mass_b  (i_mass_b),
        .i_pos_b_x (i_pos_b_x),
        .i_pos_b_y (i_pos_b_y),
        .i_pos_b_z (i_pos_b_z),
        .o_vld     (fr_vld),
        .i_rdy     (!mid_full),
        .o_mag     (fr_mag),
        .o_dir     (fr_dir),
        .o_mass_a  (fr_ma),
        .o_mass_b  (fr_mb)
    );

    // queue between front and back
    logic            mid_empty;
    logic [MIDW-1:0] mid_data;
    logic            bk_en;
    logic            bk_take;

    gpf_fifo #(.W(MIDW), .DEPTH(QDEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_vld),
        .i_data  ({fr_mb, fr_ma, fr_dir, fr_mag}),
        .o_full  (mid_full),
        .i_pop   (bk_take),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    assign bk_take = bk_en && !mid_empty;

    logic [MAGW-1:0] q_mag;
    logic [DIRW-1:0] q_dir;
    logic [MW-1:0]   q_ma;
    logic [MW-1:0]   q_mb;
    assign {q_mb, q_ma, q_dir, q_mag} = mid_data;

    // g * ma
    logic           m1_vld;
    logic [2*MW-1:0] m1_p;
    logic [SW1-1:0] m1_side;

    gpf_mul #(.AW(gpf_pkg::GRAV_W), .BW(MW), .SW(SW1)) u_mul_gm (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (!mid_empty), .i_a (r_grav), .i_b (q_ma),
        .i_side ({q_mb, q_dir, q_mag}),
        .o_vld (m1_vld), .o_p (m1_p), .o_side (m1_side)
    );

    // k = g * ma * mb
    logic           m2_vld;
    logic [KW-1:0]  m2_k;
    logic [SW2-1:0] m2_side;

    gpf_mul #(.AW(2*MW), .BW(MW), .SW(SW2)) u_mul_k (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m1_vld), .i_a (m1_p), .i_b (m1_side[SW1-1 -: MW]),
        .i_side (m1_side[SW2-1:0]),
        .o_vld (m2_vld), .o_p (m2_k), .o_side (m2_side)
    );

    // squared separations
    logic [MAGW-1:0] m2_mag;
    logic            m3_vld;
    logic [SW3-1:0]  m3_side;
    logic [2*DW-1:0] sq_x;
    logic [2*DW-1:0] sq_y;
    logic [2*DW-1:0] sq_z;
    assign m2_mag = m2_side[MAGW-1:0];

    gpf_mul #(.AW(DW), .BW(DW), .SW(SW3)) u_sq_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m2_vld), .i_a (m2_mag[0 +: DW]), .i_b (m2_mag[0 +: DW]),
        .i_side ({m2_k, m2_side}),
        .o_vld (m3_vld), .o_p (sq_x), .o_side (m3_side)
    );
    gpf_mul #(.AW(DW), .BW(DW), .SW(1)) u_sq_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m2_vld), .i_a (m2_mag[DW +: DW]), .i_b (m2_mag[DW +: DW]),
        .i_side (1'b0),
        .o_vld (), .o_p (sq_y), .o_side ()
    );
    gpf_mul #(.AW(DW), .BW(DW), .SW(1)) u_sq_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m2_vld), .i_a (m2_mag[2*DW +: DW]), .i_b (m2_mag[2*DW +: DW]),
        .i_side (1'b0),
        .o_vld (), .o_p (sq_z), .o_side ()
    );

    // sum of squares
    logic            r_sum_vld;
    logic [2*RW-1:0] r_sum;
    logic [SW3-1:0]  r_sum_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
        end else if (bk_en) begin
            r_sum_vld <= m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bk_en) begin
            r_sum      <= (2*RW)'(sq_x) + (2*RW)'(sq_y) + (2*RW)'(sq_z);
            r_sum_side <= m3_side;
        end
    end

    // distance
    logic           sq_vld;
    logic [RW-1:0]  sq_root;
    logic [SW3-1:0] sq_side;

    gpf_sqrt #(.RW(RW), .SW(SW3)) u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (r_sum_vld), .i_s (r_sum), .i_side (r_sum_side),
        .o_vld (sq_vld), .o_root (sq_root), .o_side (sq_side)
    );

    // softened distance
    logic            r_dist_vld;
    logic [DSTW-1:0] r_dist;
    logic [SW3-1:0]  r_dist_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_vld <= 1'b0;
        end else if (bk_en) begin
            r_dist_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bk_en) begin
            r_dist      <= DSTW'(sq_root) + DSTW'(r_soft);
            r_dist_side <= sq_side;
        end
    end

    // d^2 then d^3
    logic              m4_vld;
    logic [2*DSTW-1:0] m4_p;
    logic [SW4-1:0]    m4_side;

    gpf_mul #(.AW(DSTW), .BW(DSTW), .SW(SW4)) u_mul_d2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (r_dist_vld), .i_a (r_dist), .i_b (r_dist),
        .i_side ({r_dist, r_dist_side}),
        .o_vld (m4_vld), .o_p (m4_p), .o_side (m4_side)
    );

    logic           m5_vld;
    logic [D3W-1:0] m5_d3;
    logic [SW3-1:0] m5_side;

    gpf_mul #(.AW(2*DSTW), .BW(DSTW), .SW(SW3)) u_mul_d3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m4_vld), .i_a (m4_p), .i_b (m4_side[SW4-1 -: DSTW]),
        .i_side (m4_side[SW3-1:0]),
        .o_vld (m5_vld), .o_p (m5_d3), .o_side (m5_side)
    );

    // numerators k * |r_c|
    logic [KW-1:0]   m5_k;
    logic [MAGW-1:0] m5_mag;
    logic [DIRW-1:0] m5_dir;
    logic            m6_vld;
    logic [SW6-1:0]  m6_side;
    logic [NW-1:0]   num_x;
    logic [NW-1:0]   num_y;
    logic [NW-1:0]   num_z;
    assign {m5_k, m5_dir, m5_mag} = m5_side;

    gpf_mul #(.AW(KW), .BW(DW), .SW(SW6)) u_num_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m5_vld), .i_a (m5_k), .i_b (m5_mag[0 +: DW]),
        .i_side ({m5_d3, m5_dir}),
        .o_vld (m6_vld), .o_p (num_x), .o_side (m6_side)
    );
    gpf_mul #(.AW(KW), .BW(DW), .SW(1)) u_num_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m5_vld), .i_a (m5_k), .i_b (m5_mag[DW +: DW]),
        .i_side (1'b0),
        .o_vld (), .o_p (num_y), .o_side ()
    );
    gpf_mul #(.AW(KW), .BW(DW), .SW(1)) u_num_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m5_vld), .i_a (m5_k), .i_b (m5_mag[2*DW +: DW]),
        .i_side (1'b0),
        .o_vld (), .o_p (num_z), .o_side ()
    );

    // quotients
    logic [D3W-1:0]      m6_d3;
    logic [DIRW-1:0]     m6_dir;
    logic                dv_vld;
    logic [DIRW-1:0]     dv_dir;
    logic [FW-1:0]       dv_q   [3];
    logic                dv_big [3];
    gpf_pkg::t_dir [2:0] fin_dir;
    assign {m6_d3, m6_dir} = m6_side;

    gpf_div #(.NW(NW), .DVW(D3W), .QW(FW), .SW(DIRW)) u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m6_vld), .i_n (num_x), .i_d (m6_d3), .i_side (m6_dir),
        .o_vld (dv_vld), .o_q (dv_q[0]), .o_big (dv_big[0]), .o_side (dv_dir)
    );
    gpf_div #(.NW(NW), .DVW(D3W), .QW(FW), .SW(1)) u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m6_vld), .i_n (num_y), .i_d (m6_d3), .i_side (1'b0),
        .o_vld (), .o_q (dv_q[1]), .o_big (dv_big[1]), .o_side ()
    );
    gpf_div #(.NW(NW), .DVW(D3W), .QW(FW), .SW(1)) u_div_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (bk_en),
        .i_vld (m6_vld), .i_n (num_z), .i_d (m6_d3), .i_side (1'b0),
        .o_vld (), .o_q (dv_q[2]), .o_big (dv_big[2]), .o_side ()
    );

    assign fin_dir = dv_dir;

    // clip, apply sign
    logic [FW-1:0] n_force [3];
    logic [2:0]    n_clip;

    for (genvar c = 0; c < 3; c++) begin : g_fin
        logic [FW-1:0] lim;
        logic          clip;
        logic [FW-1:0] qv;
        assign lim  = fin_dir[c].pos ? gpf_pkg::FORCE_NEG_MAG : gpf_pkg::FORCE_POS_MAX;
        assign clip = dv_big[c] || (dv_q[c] > lim);
        assign qv   = clip ? lim : dv_q[c];
        assign n_force[c] = !fin_dir[c].nz ? '0 : (fin_dir[c].pos ? (FW'(0) - qv) : qv);
        assign n_clip[c]  = fin_dir[c].nz && clip;
    end

    logic          r_fin_vld;
    logic [FW-1:0] r_fx;
    logic [FW-1:0] r_fy;
    logic [FW-1:0] r_fz;
    logic          r_sat;
    logic          out_full;

    // back end moves as one unless the last result cannot leave
    assign bk_en = !(r_fin_vld && out_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (bk_en) begin
            r_fin_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bk_en) begin
            r_fx  <= n_force[0];
            r_fy  <= n_force[1];
            r_fz  <= n_force[2];
            r_sat <= |n_clip;
        end
    end

    // output queue
    logic [OUTW-1:0] out_data;

    gpf_fifo #(.W(OUTW), .DEPTH(QDEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_fin_vld),
        .i_data  ({r_sat, r_fz, r_fy, r_fx}),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign o_force_x   = out_data[0 +: FW];
    assign o_force_y   = out_data[FW +: FW];
    assign o_force_z   = out_data[2*FW +: FW];
    assign o_saturated = out_data[OUTW-1];

endmodule
`default_nettype wire

[rtl/gpf_fifo.sv]
// small show-ahead queue in flip-flops
`default_nettype none
module gpf_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= i_data;
    end

endmodule
`default_nettype wire

[rtl/gpf_front.sv]
// input stage: takes a body pair and classifies the separation per axis
`default_nettype none
module gpf_front #(
    parameter int CW = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire logic [gpf_pkg::MASS_W-1:0]  i_mass_a,
    input  wire logic signed [CW-1:0]        i_pos_a_x,
    input  wire logic signed [CW-1:0]        i_pos_a_y,
    input  wire logic signed [CW-1:0]        i_pos_a_z,
    input  wire logic [gpf_pkg::MASS_W-1:0]  i_mass_b,
    input  wire logic signed [CW-1:0]        i_pos_b_x,
    input  wire logic signed [CW-1:0]        i_pos_b_y,
    input  wire logic signed [CW-1:0]        i_pos_b_z,
    output logic                             o_vld,
    input  wire logic                        i_rdy,
    output logic [3*(CW+1)-1:0]              o_mag,
    output gpf_pkg::t_dir [2:0]              o_dir,
    output logic [gpf_pkg::MASS_W-1:0]       o_mass_a,
    output logic [gpf_pkg::MASS_W-1:0]       o_mass_b
);
    localparam int DW = CW + 1;

    logic signed [CW-1:0] pa [3];
    logic signed [CW-1:0] pb [3];
    logic [3*DW-1:0]      n_mag;
    gpf_pkg::t_dir [2:0]  n_dir;
    logic                 r_vld;
    logic [3*DW-1:0]      r_mag;
    gpf_pkg::t_dir [2:0]  r_dir;
    logic [gpf_pkg::MASS_W-1:0] r_ma;
    logic [gpf_pkg::MASS_W-1:0] r_mb;

    assign pa[0] = i_pos_a_x;
    assign pa[1] = i_pos_a_y;
    assign pa[2] = i_pos_a_z;
    assign pb[0] = i_pos_b_x;
    assign pb[1] = i_pos_b_y;
    assign pb[2] = i_pos_b_z;

    // separation magnitude and direction per axis
    for (genvar c = 0; c < 3; c++) begin : g_axis
        logic signed [DW-1:0] diff;
        assign diff = DW'(pb[c]) - DW'(pa[c]);
        assign n_mag[c*DW +: DW] = diff[DW-1] ? DW'(-diff) : DW'(diff);
        assign n_dir[c].nz  = (diff != '0);
        assign n_dir[c].pos = !diff[DW-1] && (diff != '0);
    end

    // hold stage, drains into the queue behind it
    assign o_full = r_vld && !i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_full) begin
            r_vld <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mag <= n_mag;
            r_dir <= n_dir;
            r_ma  <= i_mass_a;
            r_mb  <= i_mass_b;
        end
    end

    assign o_vld    = r_vld;
    assign o_mag    = r_mag;
    assign o_dir    = r_dir;
    assign o_mass_a = r_ma;
    assign o_mass_b = r_mb;

endmodule
`default_nettype wire

[rtl/gpf_mul.sv]
// pipelined multiplier, one 32x32 partial product per stage
`default_nettype none
module gpf_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire logic [AW-1:0]   i_a,
    input  wire logic [BW-1:0]   i_b,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_vld,
    output logic [AW+BW-1:0]     o_p,
    output logic [SW-1:0]        o_side
);
    localparam int CH = gpf_pkg::MUL_CHUNK;
    localparam int NA = (AW + CH - 1) / CH;
    localparam int NB = (BW + CH - 1) / CH;
    localparam int N  = NA * NB;
    localparam int AP = NA * CH;
    localparam int BP = NB * CH;
    localparam int PW = AW + BW;

    logic [AP-1:0] w_a    [N];
    logic [BP-1:0] w_b    [N];
    logic [PW-1:0] w_acc  [N];
    logic [SW-1:0] w_side [N];
    logic          w_vld  [N];

    logic [AP-1:0] r_a    [1:N];
    logic [BP-1:0] r_b    [1:N];
    logic [PW-1:0] r_acc  [1:N];
    logic [SW-1:0] r_side [1:N];
    logic          r_vld  [1:N];

    for (genvar s = 0; s < N; s++) begin : g_stg
        localparam int IA = s / NB;
        localparam int IB = s % NB;
        logic [2*CH-1:0]  pp;
        logic [AP+BP-1:0] pp_ext;

        // stage input
        if (s == 0) begin : g_in
            assign w_a[s]    = AP'(i_a);
            assign w_b[s]    = BP'(i_b);
            assign w_acc[s]  = '0;
            assign w_side[s] = i_side;
            assign w_vld[s]  = i_vld;
        end else begin : g_reg
            assign w_a[s]    = r_a[s];
            assign w_b[s]    = r_b[s];
            assign w_acc[s]  = r_acc[s];
            assign w_side[s] = r_side[s];
            assign w_vld[s]  = r_vld[s];
        end

        // one partial product, aligned and accumulated
        assign pp     = w_a[s][IA*CH +: CH] * w_b[s][IB*CH +: CH];
        assign pp_ext = (AP+BP)'(pp) << ((IA + IB) * CH);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[s+1]    <= w_a[s];
                r_b[s+1]    <= w_b[s];
                r_acc[s+1]  <= w_acc[s] + pp_ext[PW-1:0];
                r_side[s+1] <= w_side[s];
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_p    = r_acc[N];
    assign o_side = r_side[N];

endmodule
`default_nettype wire

[rtl/gpf_sqrt.sv]
// pipelined integer square root, one root bit per stage
`default_nettype none
module gpf_sqrt #(
    parameter int RW = 34,
    parameter int SW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire logic [2*RW-1:0] i_s,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_vld,
    output logic [RW-1:0]        o_root,
    output logic [SW-1:0]        o_side
);
    logic [2*RW-1:0] w_s    [RW];
    logic [RW+1:0]   w_rem  [RW];
    logic [RW-1:0]   w_root [RW];
    logic [SW-1:0]   w_side [RW];
    logic            w_vld  [RW];

    logic [2*RW-1:0] r_s    [1:RW];
    logic [RW+1:0]   r_rem  [1:RW];
    logic [RW-1:0]   r_root [1:RW];
    logic [SW-1:0]   r_side [1:RW];
    logic            r_vld  [1:RW];

    for (genvar s = 0; s < RW; s++) begin : g_stg
        localparam int PI = RW - 1 - s;
        logic [RW+3:0] tr;
        logic [RW+3:0] trial;
        logic          ge;
        logic [RW+3:0] diff;

        if (s == 0) begin : g_in
            assign w_s[s]    = i_s;
            assign w_rem[s]  = '0;
            assign w_root[s] = '0;
            assign w_side[s] = i_side;
            assign w_vld[s]  = i_vld;
        end else begin : g_reg
            assign w_s[s]    = r_s[s];
            assign w_rem[s]  = r_rem[s];
            assign w_root[s] = r_root[s];
            assign w_side[s] = r_side[s];
            assign w_vld[s]  = r_vld[s];
        end

        // bring down two radicand bits, try root bit one
        assign tr    = {w_rem[s], w_s[s][2*PI +: 2]};
        assign trial = (RW+4)'({w_root[s], 2'b01});
        assign ge    = (tr >= trial);
        assign diff  = ge ? (tr - trial) : tr;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[s+1]    <= w_s[s];
                r_rem[s+1]  <= diff[RW+1:0];
                r_root[s+1] <= {w_root[s][RW-2:0], ge};
                r_side[s+1] <= w_side[s];
            end
        end
    end

    assign o_vld  = r_vld[RW];
    assign o_root = r_root[RW];
    assign o_side = r_side[RW];

endmodule
`default_nettype wire

[rtl/gpf_div.sv]
// pipelined restoring divider: overflow check, then one quotient bit per stage
`default_nettype none
module gpf_div #(
    parameter int NW  = 129,
    parameter int DVW = 105,
    parameter int QW  = 48,
    parameter int SW  = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire logic [NW-1:0]  i_n,
    input  wire logic [DVW-1:0] i_d,
    input  wire logic [SW-1:0]  i_side,
    output logic                o_vld,
    output logic [QW-1:0]       o_q,
    output logic                o_big,
    output logic [SW-1:0]       o_side
);
    localparam int XW = (NW > DVW + QW) ? NW : (DVW + QW);
    localparam int N  = QW + 1;

    logic [XW-1:0]  w_rem  [N];
    logic [DVW-1:0] w_d    [N];
    logic [QW-1:0]  w_q    [N];
    logic           w_big  [N];
    logic [SW-1:0]  w_side [N];
    logic           w_vld  [N];

    logic [XW-1:0]  r_rem  [1:N];
    logic [DVW-1:0] r_d    [1:N];
    logic [QW-1:0]  r_q    [1:N];
    logic           r_big  [1:N];
    logic [SW-1:0]  r_side [1:N];
    logic           r_vld  [1:N];

    for (genvar s = 0; s < N; s++) begin : g_stg
        logic [XW-1:0] n_rem;
        logic [QW-1:0] n_q;
        logic          n_big;

        if (s == 0) begin : g_in
            assign w_rem[s]  = XW'(i_n);
            assign w_d[s]    = i_d;
            assign w_q[s]    = '0;
            assign w_big[s]  = 1'b0;
            assign w_side[s] = i_side;
            assign w_vld[s]  = i_vld;
            // quotient does not fit the result width
            assign n_big = (w_rem[s] >= (XW'(w_d[s]) << QW));
            assign n_rem = w_rem[s];
            assign n_q   = '0;
        end else begin : g_bit
            localparam int BIT = QW - s;
            logic [XW-1:0] trial;
            logic          ge;
            assign w_rem[s]  = r_rem[s];
            assign w_d[s]    = r_d[s];
            assign w_q[s]    = r_q[s];
            assign w_big[s]  = r_big[s];
            assign w_side[s] = r_side[s];
            assign w_vld[s]  = r_vld[s];
            // compare and subtract the shifted divisor
            assign trial = XW'(w_d[s]) << BIT;
            assign ge    = (w_rem[s] >= trial);
            assign n_rem = ge ? (w_rem[s] - trial) : w_rem[s];
            assign n_q   = w_q[s] | (QW'(ge) << BIT);
            assign n_big = w_big[s];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_d[s+1]    <= w_d[s];
                r_q[s+1]    <= n_q;
                r_big[s+1]  <= n_big;
                r_side[s+1] <= w_side[s];
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_q    = r_q[N];
    assign o_big  = r_big[N];
    assign o_side = r_side[N];

endmodule
`default_nettype wire
